// ===== rtl/barycentric_area_weights_macros.svh =====
// ----------------------------------------------------------------------------
// barycentric area weights assertion macros
// concurrent assertion shorthands clocked on aclk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef BARYCENTRIC_AREA_WEIGHTS_MACROS_SVH
`define BARYCENTRIC_AREA_WEIGHTS_MACROS_SVH

// same-cycle implication
`define BAW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("barycentric_area_weights: same-cycle check failed");

// next-cycle implication
`define BAW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("barycentric_area_weights: next-cycle check failed");

`endif

// ===== rtl/baw_pkg.sv =====
// ----------------------------------------------------------------------------
// baw_pkg
// shared widths, types and helpers of the barycentric area weights pipeline
// ----------------------------------------------------------------------------
package baw_pkg;

    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int COMP_W  = PROD_W + 1;
    localparam int MAG_W   = COMP_W - 1;
    localparam int HALF_W  = MAG_W / 2;
    localparam int PART_W  = 2 * HALF_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int TRIAL_W = SUM_W + 1;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int TOT_W   = ROOT_W + 2;

    localparam int TPROD_W = COORD_W + WEIGHT_W + 1;
    localparam int ACC_W   = TPROD_W + 2;

    localparam int AREA_STAGES = 7;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = WEIGHT_FRAC_BITS + 2;
    localparam int TEX_STAGES  = 2;
    localparam int LANES       = 3;

    localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
    localparam int COORD_MIN = -(2 ** (COORD_W - 1));

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [COMP_W-1:0]  comp_t;
    typedef logic [MAG_W-1:0]          mag_t;
    typedef logic [PART_W-1:0]         part_t;
    typedef logic [SQ_W-1:0]           sq_t;
    typedef logic [SUM_W-1:0]          sum_t;
    typedef logic [TRIAL_W-1:0]        trial_t;
    typedef logic [ROOT_W-1:0]         root_t;
    typedef logic [TOT_W-1:0]          tot_t;
    typedef logic [TOT_W:0]            shrem_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;
    typedef logic signed [TPROD_W-1:0] tprod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // vertex coordinates needed for the texture mix at the end
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } tex_side_t;

    // first and second difference vector of each area lane (u, v, w)
    function automatic int lane_p(input int l);
        return (l == 0) ? 1 : 0;
    endfunction

    function automatic int lane_q(input int l);
        return (l == 2) ? 1 : 2;
    endfunction

    // axes feeding cross product component c
    function automatic int axis_a(input int c);
        return (c == 2) ? 0 : c + 1;
    endfunction

    function automatic int axis_b(input int c);
        return (c == 0) ? 2 : c - 1;
    endfunction

endpackage

// ===== rtl/barycentric_area_weights.sv =====
// stages: 7 area, 51 root, 18 divide and 2 texture stages from input beat to result beat
// throughput: one beat per cycle while results are taken; every stage holds its
//   own valid bit and loads whenever the stage after it is empty or moving
// reset: synchronous active-low aresetn clears every valid bit; data registers
//   are not reset
// ----------------------------------------------------------------------------
// barycentric_area_weights
// barycentric weights from sub-triangle areas plus a weighted 2-D coordinate
// ----------------------------------------------------------------------------
`include "barycentric_area_weights_macros.svh"

module barycentric_area_weights (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_a_x,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_a_y,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_a_z,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_b_x,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_b_y,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_b_z,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_c_x,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_c_y,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_c_z,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_pt_x,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_pt_y,
    input  logic signed [baw_pkg::COORD_W-1:0]  s_pt_z,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [baw_pkg::WEIGHT_W-1:0]        m_weight_u,
    output logic [baw_pkg::WEIGHT_W-1:0]        m_weight_v,
    output logic [baw_pkg::WEIGHT_W-1:0]        m_weight_w,
    output logic signed [baw_pkg::COORD_W-1:0]  m_tex_s,
    output logic signed [baw_pkg::COORD_W-1:0]  m_tex_t,
    output logic                                m_degenerate
);

    localparam int L = baw_pkg::LANES;
    localparam int F = baw_pkg::WEIGHT_FRAC_BITS;
    localparam int T = baw_pkg::TEX_STAGES;

    // lane order u, v, w throughout
    localparam int LANE_U = 0;
    localparam int LANE_V = 1;
    localparam int LANE_W = 2;

    baw_pkg::coord_t    vtx [4][3];
    baw_pkg::tex_side_t side_in;

    // area to root
    logic               area_valid, area_ready;
    baw_pkg::sum_t      area_sum  [L];
    baw_pkg::tex_side_t area_side;

    // root to divider
    logic               root_valid, root_ready;
    baw_pkg::root_t     root_val  [L];
    baw_pkg::tex_side_t root_side;

    // divider to texture stages
    logic               div_valid, div_ready;
    baw_pkg::weight_t   div_weight [L];
    logic               div_degen;
    baw_pkg::tex_side_t div_side;

    // texture stages
    logic               vld_reg [T];
    logic [T:0]         ld;
    baw_pkg::weight_t   wz_next   [L];
    baw_pkg::weight_t   w0_reg    [L];
    logic               degen0_reg;
    baw_pkg::tprod_t    ps_reg    [L];
    baw_pkg::tprod_t    pt_reg    [L];
    baw_pkg::weight_t   w1_reg    [L];
    logic               degen1_reg;
    baw_pkg::coord_t    tex_s_next, tex_t_next;
    baw_pkg::coord_t    tex_s_reg,  tex_t_reg;

    logic [baw_pkg::WEIGHT_W+1:0] wsum;

    // coordinate bundle: vertex a, b, c, then the point
    assign vtx[0] = '{s_a_x,  s_a_y,  s_a_z};
    assign vtx[1] = '{s_b_x,  s_b_y,  s_b_z};
    assign vtx[2] = '{s_c_x,  s_c_y,  s_c_z};
    assign vtx[3] = '{s_pt_x, s_pt_y, s_pt_z};

    // only the xy of each vertex is needed after the areas
    assign side_in = '{ax: s_a_x, ay: s_a_y, bx: s_b_x, by: s_b_y, cx: s_c_x, cy: s_c_y};

    // differences, cross products, squared lengths
    baw_area u_area (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .vtx       (vtx),
        .side_in   (side_in),
        .out_valid (area_valid),
        .out_ready (area_ready),
        .sum_out   (area_sum),
        .side_out  (area_side)
    );

    // one root bit per stage, the unscaled areas
    baw_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (area_valid),
        .in_ready  (area_ready),
        .rad_in    (area_sum),
        .side_in   (area_side),
        .out_valid (root_valid),
        .out_ready (root_ready),
        .root_out  (root_val),
        .side_out  (root_side)
    );

    // total, zero-area detect and area over total
    baw_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (root_valid),
        .in_ready   (root_ready),
        .area_in    (root_val),
        .side_in    (root_side),
        .out_valid  (div_valid),
        .out_ready  (div_ready),
        .weight_out (div_weight),
        .degen_out  (div_degen),
        .side_out   (div_side)
    );

    // texture stage handshake, last stage is the output register
    assign ld[T] = m_ready;
    for (genvar k = 0; k < T; k++) begin : g_ld
        assign ld[k] = !vld_reg[k] || ld[k+1];
    end
    assign div_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < T; k++) vld_reg[k] <= 1'b0;
        end else begin
            if (ld[0]) vld_reg[0] <= div_valid;
            if (ld[1]) vld_reg[1] <= vld_reg[0];
        end
    end

    // a zero total forces zero weights, which also makes both tex sums zero
    always_comb begin
        for (int l = 0; l < L; l++) begin
            wz_next[l] = div_degen ? '0 : div_weight[l];
        end
    end

    // products: a pairs with w, b with v, c with u
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            degen0_reg <= div_degen;
            for (int l = 0; l < L; l++) w0_reg[l] <= wz_next[l];
            ps_reg[0] <= baw_pkg::tprod_t'(div_side.ax)
                       * baw_pkg::tprod_t'($signed({1'b0, wz_next[LANE_W]}));
            ps_reg[1] <= baw_pkg::tprod_t'(div_side.bx)
                       * baw_pkg::tprod_t'($signed({1'b0, wz_next[LANE_V]}));
            ps_reg[2] <= baw_pkg::tprod_t'(div_side.cx)
                       * baw_pkg::tprod_t'($signed({1'b0, wz_next[LANE_U]}));
            pt_reg[0] <= baw_pkg::tprod_t'(div_side.ay)
                       * baw_pkg::tprod_t'($signed({1'b0, wz_next[LANE_W]}));
            pt_reg[1] <= baw_pkg::tprod_t'(div_side.by)
                       * baw_pkg::tprod_t'($signed({1'b0, wz_next[LANE_V]}));
            pt_reg[2] <= baw_pkg::tprod_t'(div_side.cy)
                       * baw_pkg::tprod_t'($signed({1'b0, wz_next[LANE_U]}));
        end
    end

    // sum, drop the 16 fraction bits rounding half up, saturate to the coordinate range
    always_comb begin
        baw_pkg::acc_t acc_s, acc_t, rnd_s, rnd_t;
        acc_s = baw_pkg::acc_t'(ps_reg[0]) + baw_pkg::acc_t'(ps_reg[1])
              + baw_pkg::acc_t'(ps_reg[2]);
        acc_t = baw_pkg::acc_t'(pt_reg[0]) + baw_pkg::acc_t'(pt_reg[1])
              + baw_pkg::acc_t'(pt_reg[2]);
        rnd_s = (acc_s + (baw_pkg::acc_t'(1) <<< (F - 1))) >>> F;
        rnd_t = (acc_t + (baw_pkg::acc_t'(1) <<< (F - 1))) >>> F;
        if (rnd_s > baw_pkg::acc_t'(baw_pkg::COORD_MAX)) begin
            tex_s_next = baw_pkg::coord_t'(baw_pkg::COORD_MAX);
        end else if (rnd_s < baw_pkg::acc_t'(baw_pkg::COORD_MIN)) begin
            tex_s_next = baw_pkg::coord_t'(baw_pkg::COORD_MIN);
        end else begin
            tex_s_next = baw_pkg::coord_t'(rnd_s);
        end
        if (rnd_t > baw_pkg::acc_t'(baw_pkg::COORD_MAX)) begin
            tex_t_next = baw_pkg::coord_t'(baw_pkg::COORD_MAX);
        end else if (rnd_t < baw_pkg::acc_t'(baw_pkg::COORD_MIN)) begin
            tex_t_next = baw_pkg::coord_t'(baw_pkg::COORD_MIN);
        end else begin
            tex_t_next = baw_pkg::coord_t'(rnd_t);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            degen1_reg <= degen0_reg;
            for (int l = 0; l < L; l++) w1_reg[l] <= w0_reg[l];
            tex_s_reg <= tex_s_next;
            tex_t_reg <= tex_t_next;
        end
    end

    assign m_valid      = vld_reg[T-1];
    assign m_weight_u   = w1_reg[LANE_U];
    assign m_weight_v   = w1_reg[LANE_V];
    assign m_weight_w   = w1_reg[LANE_W];
    assign m_tex_s      = tex_s_reg;
    assign m_tex_t      = tex_t_reg;
    assign m_degenerate = degen1_reg;

    assign wsum = (baw_pkg::WEIGHT_W+2)'(m_weight_u) + (baw_pkg::WEIGHT_W+2)'(m_weight_v)
                + (baw_pkg::WEIGHT_W+2)'(m_weight_w);

    // a zero-area beat carries all-zero weights and coordinates
    `BAW_ASSERT_IMP(a_degen_zero, m_valid && m_degenerate, wsum == '0 && m_tex_s == '0 && m_tex_t == '0)
    // the three weights never add up to more than one
    `BAW_ASSERT_IMP(a_wsum_le_one, m_valid, wsum <= ((baw_pkg::WEIGHT_W+2)'(1) << F))
    // input backpressure only when the whole pipe is full behind a stalled result
    `BAW_ASSERT_IMP(a_ready_full, !s_ready, m_valid && !m_ready)
    // the coordinates of a held result beat are not overwritten while it waits
    `BAW_ASSERT_NXT(a_hold_tex, m_valid && !m_ready, $stable(m_tex_s) && $stable(m_tex_t))

endmodule

// ===== rtl/baw_area.sv =====
// ----------------------------------------------------------------------------
// baw_area
// differences, cross products and squared lengths of the three sub-triangles
// ----------------------------------------------------------------------------
module baw_area (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  baw_pkg::coord_t     vtx [4][3],
    input  baw_pkg::tex_side_t  side_in,
    output logic                out_valid,
    input  logic                out_ready,
    output baw_pkg::sum_t       sum_out [baw_pkg::LANES],
    output baw_pkg::tex_side_t  side_out
);

    localparam int N = baw_pkg::AREA_STAGES;
    localparam int L = baw_pkg::LANES;
    localparam int H = baw_pkg::HALF_W;
    localparam int M = baw_pkg::MAG_W;

    logic               vld_reg [N];
    logic [N:0]         ld;
    baw_pkg::tex_side_t side_reg [N];

    baw_pkg::diff_t d_reg    [3][3];
    baw_pkg::prod_t prod_reg [L][3][2];
    baw_pkg::comp_t comp_reg [L][3];
    baw_pkg::mag_t  mag_reg  [L][3];
    baw_pkg::part_t hh_reg   [L][3];
    baw_pkg::part_t hl_reg   [L][3];
    baw_pkg::part_t ll_reg   [L][3];
    baw_pkg::sq_t   sq_reg   [L][3];
    baw_pkg::sum_t  sum_reg  [L];

    assign ld[N] = out_ready;
    for (genvar k = 0; k < N; k++) begin : g_ld
        assign ld[k] = !vld_reg[k] || ld[k+1];
    end
    assign in_ready = ld[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) vld_reg[k] <= 1'b0;
        end else begin
            if (ld[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < N; k++) begin
                if (ld[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) side_reg[0] <= side_in;
        for (int k = 1; k < N; k++) begin
            if (ld[k]) side_reg[k] <= side_reg[k-1];
        end
        // point minus each vertex
        if (ld[0]) begin
            for (int v = 0; v < 3; v++) begin
                for (int a = 0; a < 3; a++) begin
                    d_reg[v][a] <= baw_pkg::diff_t'(vtx[3][a]) - baw_pkg::diff_t'(vtx[v][a]);
                end
            end
        end
        // cross product partial products
        if (ld[1]) begin
            for (int l = 0; l < L; l++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[l][c][0] <=
                        baw_pkg::prod_t'(d_reg[baw_pkg::lane_p(l)][baw_pkg::axis_a(c)]) *
                        baw_pkg::prod_t'(d_reg[baw_pkg::lane_q(l)][baw_pkg::axis_b(c)]);
                    prod_reg[l][c][1] <=
                        baw_pkg::prod_t'(d_reg[baw_pkg::lane_p(l)][baw_pkg::axis_b(c)]) *
                        baw_pkg::prod_t'(d_reg[baw_pkg::lane_q(l)][baw_pkg::axis_a(c)]);
                end
            end
        end
        for (int l = 0; l < L; l++) begin
            for (int c = 0; c < 3; c++) begin
                if (ld[2]) begin
                    comp_reg[l][c] <= baw_pkg::comp_t'(prod_reg[l][c][0])
                                    - baw_pkg::comp_t'(prod_reg[l][c][1]);
                end
                if (ld[3]) begin
                    mag_reg[l][c] <= (comp_reg[l][c] < 0) ? baw_pkg::mag_t'(-comp_reg[l][c])
                                                          : baw_pkg::mag_t'(comp_reg[l][c]);
                end
                // square split into halves to keep the multipliers narrow
                if (ld[4]) begin
                    hh_reg[l][c] <= baw_pkg::part_t'(mag_reg[l][c][M-1:H])
                                  * baw_pkg::part_t'(mag_reg[l][c][M-1:H]);
                    hl_reg[l][c] <= baw_pkg::part_t'(mag_reg[l][c][M-1:H])
                                  * baw_pkg::part_t'(mag_reg[l][c][H-1:0]);
                    ll_reg[l][c] <= baw_pkg::part_t'(mag_reg[l][c][H-1:0])
                                  * baw_pkg::part_t'(mag_reg[l][c][H-1:0]);
                end
                if (ld[5]) begin
                    sq_reg[l][c] <= (baw_pkg::sq_t'(hh_reg[l][c]) << (2 * H))
                                  + (baw_pkg::sq_t'(hl_reg[l][c]) << (H + 1))
                                  + baw_pkg::sq_t'(ll_reg[l][c]);
                end
            end
            if (ld[6]) begin
                sum_reg[l] <= baw_pkg::sum_t'(sq_reg[l][0]) + baw_pkg::sum_t'(sq_reg[l][1])
                            + baw_pkg::sum_t'(sq_reg[l][2]);
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign sum_out   = sum_reg;
    assign side_out  = side_reg[N-1];

endmodule

// ===== rtl/baw_sqrt.sv =====
// ----------------------------------------------------------------------------
// baw_sqrt
// three-lane pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module baw_sqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  baw_pkg::sum_t       rad_in [baw_pkg::LANES],
    input  baw_pkg::tex_side_t  side_in,
    output logic                out_valid,
    input  logic                out_ready,
    output baw_pkg::root_t      root_out [baw_pkg::LANES],
    output baw_pkg::tex_side_t  side_out
);

    localparam int N = baw_pkg::SQRT_STAGES;
    localparam int L = baw_pkg::LANES;

    logic               vld_reg  [N];
    logic [N:0]         ld;
    baw_pkg::tex_side_t side_reg [N];
    baw_pkg::sum_t      rem_reg  [L][N];
    baw_pkg::root_t     root_reg [L][N];

    assign ld[N] = out_ready;
    assign in_ready = ld[0];

    for (genvar j = 0; j < N; j++) begin : g_step
        localparam int B = N - 1 - j;

        logic               src_vld;
        baw_pkg::tex_side_t src_side;
        baw_pkg::sum_t      src_rem  [L];
        baw_pkg::root_t     src_root [L];
        baw_pkg::trial_t    trial    [L];
        baw_pkg::sum_t      rem_next [L];
        baw_pkg::root_t     root_next[L];

        assign ld[j] = !vld_reg[j] || ld[j+1];

        if (j == 0) begin : g_src
            assign src_vld  = in_valid;
            assign src_side = side_in;
            for (genvar l = 0; l < L; l++) begin : g_lane
                assign src_rem[l]  = rad_in[l];
                assign src_root[l] = '0;
            end
        end else begin : g_src
            assign src_vld  = vld_reg[j-1];
            assign src_side = side_reg[j-1];
            for (genvar l = 0; l < L; l++) begin : g_lane
                assign src_rem[l]  = rem_reg[l][j-1];
                assign src_root[l] = root_reg[l][j-1];
            end
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        always_comb begin
            for (int l = 0; l < L; l++) begin
                trial[l] = (baw_pkg::trial_t'(src_root[l]) << (B + 1))
                         | (baw_pkg::trial_t'(1) << (2 * B));
                if (baw_pkg::trial_t'(src_rem[l]) >= trial[l]) begin
                    rem_next[l]  = baw_pkg::sum_t'(baw_pkg::trial_t'(src_rem[l]) - trial[l]);
                    root_next[l] = src_root[l] | (baw_pkg::root_t'(1) << B);
                end else begin
                    rem_next[l]  = src_rem[l];
                    root_next[l] = src_root[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (ld[j]) begin
                vld_reg[j] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (ld[j]) begin
                side_reg[j] <= src_side;
                for (int l = 0; l < L; l++) begin
                    rem_reg[l][j]  <= rem_next[l];
                    root_reg[l][j] <= root_next[l];
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign side_out  = side_reg[N-1];
    for (genvar l = 0; l < L; l++) begin : g_out
        assign root_out[l] = root_reg[l][N-1];
    end

endmodule

// ===== rtl/baw_div.sv =====
// ----------------------------------------------------------------------------
// baw_div
// area total and three-lane pipelined restoring division, one quotient bit
// per stage
// ----------------------------------------------------------------------------
module baw_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  baw_pkg::root_t      area_in [baw_pkg::LANES],
    input  baw_pkg::tex_side_t  side_in,
    output logic                out_valid,
    input  logic                out_ready,
    output baw_pkg::weight_t    weight_out [baw_pkg::LANES],
    output logic                degen_out,
    output baw_pkg::tex_side_t  side_out
);

    localparam int N = baw_pkg::DIV_STAGES;
    localparam int L = baw_pkg::LANES;
    localparam int W = baw_pkg::WEIGHT_W;

    logic               vld_reg   [N];
    logic [N:0]         ld;
    baw_pkg::tex_side_t side_reg  [N];
    logic               degen_reg [N];
    baw_pkg::tot_t      den_reg   [N];
    baw_pkg::tot_t      rem_reg   [L][N];
    baw_pkg::weight_t   q_reg     [L][N];

    baw_pkg::tot_t      total_next;

    assign ld[N] = out_ready;
    assign in_ready = ld[0];
    for (genvar k = 0; k < N; k++) begin : g_ld
        assign ld[k] = !vld_reg[k] || ld[k+1];
    end

    assign total_next = baw_pkg::tot_t'(area_in[0]) + baw_pkg::tot_t'(area_in[1])
                      + baw_pkg::tot_t'(area_in[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) vld_reg[k] <= 1'b0;
        end else begin
            if (ld[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < N; k++) begin
                if (ld[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // total and the integer quotient bit
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            side_reg[0]  <= side_in;
            den_reg[0]   <= total_next;
            degen_reg[0] <= (total_next == '0);
            for (int l = 0; l < L; l++) begin
                rem_reg[l][0] <= baw_pkg::tot_t'(area_in[l]);
                q_reg[l][0]   <= '0;
            end
        end
        if (ld[1]) begin
            side_reg[1]  <= side_reg[0];
            den_reg[1]   <= den_reg[0];
            degen_reg[1] <= degen_reg[0];
            for (int l = 0; l < L; l++) begin
                if (rem_reg[l][0] >= den_reg[0]) begin
                    rem_reg[l][1] <= rem_reg[l][0] - den_reg[0];
                    q_reg[l][1]   <= baw_pkg::weight_t'(1);
                end else begin
                    rem_reg[l][1] <= rem_reg[l][0];
                    q_reg[l][1]   <= '0;
                end
            end
        end
    end

    for (genvar k = 2; k < N; k++) begin : g_step
        baw_pkg::shrem_t sh [L];

        always_comb begin
            for (int l = 0; l < L; l++) begin
                sh[l] = {rem_reg[l][k-1], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ld[k]) begin
                side_reg[k]  <= side_reg[k-1];
                den_reg[k]   <= den_reg[k-1];
                degen_reg[k] <= degen_reg[k-1];
                for (int l = 0; l < L; l++) begin
                    if (sh[l] >= {1'b0, den_reg[k-1]}) begin
                        rem_reg[l][k] <= baw_pkg::tot_t'(sh[l] - {1'b0, den_reg[k-1]});
                        q_reg[l][k]   <= {q_reg[l][k-1][W-2:0], 1'b1};
                    end else begin
                        rem_reg[l][k] <= baw_pkg::tot_t'(sh[l]);
                        q_reg[l][k]   <= {q_reg[l][k-1][W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign degen_out = degen_reg[N-1];
    assign side_out  = side_reg[N-1];
    for (genvar l = 0; l < L; l++) begin : g_out
        assign weight_out[l] = q_reg[l][N-1];
    end

endmodule
